// ===== design/uvs_pkg.sv =====
// ----------------------------------------------------------------------------
// uvs_pkg
// Shared constants and types for the UV-sphere vertex generator.
// ----------------------------------------------------------------------------
package uvs_pkg;

    localparam int APB_AW = 5;

    // quotient bits of every angle divider lane
    localparam int QW = 31;

    localparam logic [29:0] PI_Q28     = 30'h3243F6A8;
    localparam logic [30:0] TWO_PI_Q28 = 31'h6487ED50;
    localparam logic [30:0] ONE_Q30    = 31'h40000000;

    // Horner steps of the sine and cosine series
    localparam int SC_NSTEP = 4;
    localparam int SC_LAT   = 3 * SC_NSTEP + 3;

    localparam logic [7:0] SIN_DIV [SC_NSTEP] = '{8'd72, 8'd42, 8'd20, 8'd6};
    localparam logic [7:0] COS_DIV [SC_NSTEP] = '{8'd56, 8'd30, 8'd12, 8'd2};
    localparam logic [29:0] SIN_RCP [SC_NSTEP] = '{
        30'((1 << 30) / 72), 30'((1 << 30) / 42),
        30'((1 << 30) / 20), 30'((1 << 30) / 6)};
    localparam logic [29:0] COS_RCP [SC_NSTEP] = '{
        30'((1 << 30) / 56), 30'((1 << 30) / 30),
        30'((1 << 30) / 12), 30'((1 << 30) / 2)};

    typedef enum logic [2:0] {
        CFG_CENTER_X = 3'd0,
        CFG_CENTER_Y = 3'd1,
        CFG_CENTER_Z = 3'd2,
        CFG_RADIUS_X = 3'd3,
        CFG_RADIUS_Y = 3'd4,
        CFG_RADIUS_Z = 3'd5,
        CFG_RINGS    = 3'd6,
        CFG_SIDES    = 3'd7
    } cfg_reg_t;

    // octant parity and quadrant of a reduced angle
    typedef struct packed {
        logic       odd;
        logic [1:0] quad;
    } trig_ctl_t;

endpackage

// ===== design/uvs_sincos.sv =====
// ----------------------------------------------------------------------------
// uvs_sincos
// Pipelined Q30 sine and cosine of an octant angle with quadrant fix-up.
// ----------------------------------------------------------------------------
module uvs_sincos
    import uvs_pkg::*;
(
    input  logic               aclk,
    input  logic               en,
    input  logic [29:0]        x,
    input  trig_ctl_t          ctl,
    output logic signed [31:0] sin_q,
    output logic signed [31:0] cos_q
);

    localparam int NS = 3 * SC_NSTEP;

    logic [29:0] x2_reg  [0:NS-3];
    logic [29:0] x_reg   [0:NS];
    trig_ctl_t   ctl_reg [0:NS+1];

    logic [30:0] ps_reg  [SC_NSTEP];
    logic [30:0] pc_reg  [SC_NSTEP];
    logic [30:0] psd_reg [SC_NSTEP];
    logic [30:0] pcd_reg [SC_NSTEP];
    logic [60:0] ms_reg  [SC_NSTEP];
    logic [60:0] mc_reg  [SC_NSTEP];
    logic [30:0] ts_reg  [SC_NSTEP];
    logic [30:0] tc_reg  [SC_NSTEP];

    logic [30:0] tin_s  [SC_NSTEP];
    logic [30:0] tin_c  [SC_NSTEP];
    logic [60:0] pa_s   [SC_NSTEP];
    logic [60:0] pa_c   [SC_NSTEP];
    logic [30:0] ts_next [SC_NSTEP];
    logic [30:0] tc_next [SC_NSTEP];

    logic [59:0] sq;
    logic [60:0] sprod;
    logic [30:0] s_reg;
    logic [30:0] c_reg;
    logic [30:0] qs;
    logic [30:0] qc;
    logic signed [31:0] sin_next;
    logic signed [31:0] cos_next;
    logic signed [31:0] sin_reg;
    logic signed [31:0] cos_reg;

    always_comb begin
        logic [30:0] q0s;
        logic [30:0] q0c;
        logic [31:0] rms;
        logic [31:0] rmc;
        sq = 60'(x) * 60'(x);
        for (int j = 0; j < SC_NSTEP; j++) begin
            tin_s[j] = (j == 0) ? ONE_Q30 : ts_reg[(j == 0) ? 0 : j - 1];
            tin_c[j] = (j == 0) ? ONE_Q30 : tc_reg[(j == 0) ? 0 : j - 1];
            pa_s[j] = 61'(x2_reg[3 * j]) * 61'(tin_s[j]);
            pa_c[j] = 61'(x2_reg[3 * j]) * 61'(tin_c[j]);
            q0s = ms_reg[j][60:30];
            q0c = mc_reg[j][60:30];
            rms = 32'(psd_reg[j]) - 32'(q0s) * 32'(SIN_DIV[j]);
            rmc = 32'(pcd_reg[j]) - 32'(q0c) * 32'(COS_DIV[j]);
            ts_next[j] = ONE_Q30 - (q0s + 31'(rms >= 32'(SIN_DIV[j])));
            tc_next[j] = ONE_Q30 - (q0c + 31'(rmc >= 32'(COS_DIV[j])));
        end
        sprod = 61'(x_reg[NS]) * 61'(ts_reg[SC_NSTEP-1]);
    end

    always_comb begin
        if (ctl_reg[NS+1].odd) begin
            qs = c_reg;
            qc = s_reg;
        end else begin
            qs = s_reg;
            qc = c_reg;
        end
        case (ctl_reg[NS+1].quad)
            2'd0: begin
                sin_next = $signed({1'b0, qs});
                cos_next = $signed({1'b0, qc});
            end
            2'd1: begin
                sin_next = $signed({1'b0, qc});
                cos_next = -$signed({1'b0, qs});
            end
            2'd2: begin
                sin_next = -$signed({1'b0, qs});
                cos_next = -$signed({1'b0, qc});
            end
            default: begin
                sin_next = -$signed({1'b0, qc});
                cos_next = $signed({1'b0, qs});
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x2_reg[0]  <= sq[59:30];
            x_reg[0]   <= x;
            ctl_reg[0] <= ctl;
            for (int s = 1; s <= NS - 3; s++) begin
                x2_reg[s] <= x2_reg[s-1];
            end
            for (int s = 1; s <= NS; s++) begin
                x_reg[s] <= x_reg[s-1];
            end
            for (int s = 1; s <= NS + 1; s++) begin
                ctl_reg[s] <= ctl_reg[s-1];
            end
            for (int j = 0; j < SC_NSTEP; j++) begin
                ps_reg[j]  <= pa_s[j][60:30];
                pc_reg[j]  <= pa_c[j][60:30];
                ms_reg[j]  <= 61'(ps_reg[j]) * 61'(SIN_RCP[j]);
                mc_reg[j]  <= 61'(pc_reg[j]) * 61'(COS_RCP[j]);
                psd_reg[j] <= ps_reg[j];
                pcd_reg[j] <= pc_reg[j];
                ts_reg[j]  <= ts_next[j];
                tc_reg[j]  <= tc_next[j];
            end
            s_reg   <= sprod[60:30];
            c_reg   <= tc_reg[SC_NSTEP-1];
            sin_reg <= sin_next;
            cos_reg <= cos_next;
        end
    end

    assign sin_q = sin_reg;
    assign cos_q = cos_reg;

endmodule

// ===== design/uv_sphere_vertex_generator.sv =====
// ----------------------------------------------------------------------------
// uv_sphere_vertex_generator
// Vertex position, normal and texture coordinate of one ellipsoid grid point.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one word per grid point (ring_index, side_index), valid/ready.
//   m_ channel: one vertex word per grid point, in order, valid/ready.
//   APB port: centre, radii and ring/side counts; write only while idle.
//   Latency: 4 + 31 + 18 = 53 register stages, set by the 31 quotient bits
//   of the angle dividers, one bit per stage, followed by the series
//   evaluation pipeline.
//   Throughput: one word per cycle while the pipeline is not stalled.
//   Stall: the whole pipeline holds while m_valid is high and m_ready low;
//   s_ready then drops, nothing is lost or repeated.
//   Reset: aresetn clears the pipeline valid bits and loads the registers
//   with centre 0, radii 1.0, 16 rings and 32 sides.
// ----------------------------------------------------------------------------
module uv_sphere_vertex_generator
    import uvs_pkg::*;
#(
    parameter int MAX_RINGS = 32,
    parameter int MAX_SIDES = 64
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [APB_AW-1:0]                  paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [$clog2(MAX_RINGS+1)-1:0]     s_ring_index,
    input  logic [$clog2(MAX_SIDES+1)-1:0]     s_side_index,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [31:0]                 m_pos_x,
    output logic signed [31:0]                 m_pos_y,
    output logic signed [31:0]                 m_pos_z,
    output logic signed [15:0]                 m_norm_x,
    output logic signed [15:0]                 m_norm_y,
    output logic signed [15:0]                 m_norm_z,
    output logic [30:0]                        m_tex_u,
    output logic [30:0]                        m_tex_v
);

    localparam int RIW   = $clog2(MAX_RINGS + 1);
    localparam int SIW   = $clog2(MAX_SIDES + 1);
    localparam int NMAX  = (2 * MAX_RINGS > MAX_SIDES) ? 2 * MAX_RINGS : MAX_SIDES;
    localparam int DW    = $clog2(NMAX + 1);
    localparam int EW    = DW + 4;
    localparam int NW    = DW + QW;
    localparam int TOTAL = 4 + QW + SC_LAT + 3;
    localparam int RING_RST = (MAX_RINGS < 16) ? MAX_RINGS : 16;
    localparam int SIDE_RST = (MAX_SIDES < 32) ? MAX_SIDES : 32;

    // configuration
    logic signed [31:0] center_x_reg, center_y_reg, center_z_reg;
    logic [30:0]        radius_x_reg, radius_y_reg, radius_z_reg;
    logic [RIW-1:0]     rings_reg;
    logic [SIW-1:0]     sides_reg;
    logic               wr_en;
    cfg_reg_t           wr_idx;
    logic [RIW-1:0]     wr_rings;
    logic [SIW-1:0]     wr_sides;

    // pipeline control
    logic [TOTAL-1:0]   vld_reg;
    logic               adv;

    // front stages
    logic [RIW-1:0]     ring1_reg, ring2_reg;
    logic [SIW-1:0]     side1_reg, side2_reg;
    logic [3:0]         op_reg, ot_reg;
    logic [3:0]         op_next, ot_next;
    logic [EW-1:0]      np, nt, ep2, et2;
    logic [EW-1:0]      rp_w, rt_w;
    logic [DW-1:0]      rp_reg, rt_reg;
    trig_ctl_t          ctlp_reg, ctlt_reg;
    logic [NW-1:0]      nth_reg, nph_reg;
    logic [NW-1:0]      num [4];

    // divider lanes: 0 polar angle, 1 azimuth, 2 theta, 3 phi
    logic [DW-1:0]      dv_div [4];
    logic [DW-1:0]      dv_rem_reg [4][QW+1];
    logic [QW-1:0]      dv_lo_reg  [4][QW+1];
    trig_ctl_t          dv_ctl_reg [2][QW+1];
    logic [DW:0]        dv_tr [4][QW+1];
    logic               dv_ge [4][QW+1];

    // trig and back end
    logic signed [31:0] sp, cp, st, ct;
    logic signed [31:0] nx_reg, ny_reg, nz_reg;
    logic [31:0]        pmx_reg, pmy_reg, pmz_reg;
    logic               ngx_reg, ngy_reg, ngz_reg;
    logic signed [15:0] qx_reg, qy_reg, qz_reg;
    logic signed [31:0] posx_reg, posy_reg, posz_reg;
    logic signed [15:0] normx_reg, normy_reg, normz_reg;

    // texture coordinates
    logic [62:0]        pu_reg;
    logic [61:0]        pv_reg;
    logic [63:0]        ur, vr;
    logic [30:0]        u_next, v_next;
    logic [30:0]        u_reg [0:SC_LAT+1];
    logic [30:0]        v_reg [0:SC_LAT+1];

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        mag32 = v[31] ? 32'(-v) : 32'(v);
    endfunction

    function automatic logic signed [31:0] smul30(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
        logic [63:0] p;
        p = (64'(mag32(a)) * 64'(mag32(b)) + 64'(1 << 29)) >> 30;
        smul30 = (a[31] != b[31]) ? -$signed(p[31:0]) : $signed(p[31:0]);
    endfunction

    function automatic logic [31:0] scale(input logic signed [31:0] n,
                                          input logic [30:0] rad);
        logic [63:0] p;
        p = (64'(mag32(n)) * 64'(rad) + 64'(1 << 29)) >> 30;
        scale = p[31:0];
    endfunction

    function automatic logic signed [15:0] to_q14(input logic signed [31:0] v);
        logic [31:0] r;
        r = (mag32(v) + 32'd32768) >> 16;
        to_q14 = v[31] ? -$signed(r[15:0]) : $signed(r[15:0]);
    endfunction

    function automatic logic signed [31:0] place(input logic signed [31:0] ctr,
                                                 input logic [31:0] pm,
                                                 input logic neg);
        logic signed [33:0] s;
        s = 34'(ctr) + (neg ? -$signed({2'b0, pm}) : $signed({2'b0, pm}));
        if (s > 34'sh0_7FFF_FFFF) begin
            place = 32'sh7FFF_FFFF;
        end else if (s < -34'sh0_8000_0000) begin
            place = 32'sh8000_0000;
        end else begin
            place = s[31:0];
        end
    endfunction

    // ------------------------------------------------------------------ APB
    assign pready   = 1'b1;
    assign wr_en    = psel && penable && pwrite;
    assign wr_idx   = cfg_reg_t'(paddr[4:2]);
    assign wr_rings = (pwdata[RIW-1:0] < RIW'(2)) ? RIW'(2) :
                      (pwdata[RIW-1:0] > RIW'(MAX_RINGS)) ? RIW'(MAX_RINGS) :
                      pwdata[RIW-1:0];
    assign wr_sides = (pwdata[SIW-1:0] < SIW'(3)) ? SIW'(3) :
                      (pwdata[SIW-1:0] > SIW'(MAX_SIDES)) ? SIW'(MAX_SIDES) :
                      pwdata[SIW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_x_reg <= '0;
            center_y_reg <= '0;
            center_z_reg <= '0;
            radius_x_reg <= 31'd65536;
            radius_y_reg <= 31'd65536;
            radius_z_reg <= 31'd65536;
            rings_reg    <= RIW'(RING_RST);
            sides_reg    <= SIW'(SIDE_RST);
        end else if (wr_en) begin
            case (wr_idx)
                CFG_CENTER_X: center_x_reg <= pwdata;
                CFG_CENTER_Y: center_y_reg <= pwdata;
                CFG_CENTER_Z: center_z_reg <= pwdata;
                CFG_RADIUS_X: radius_x_reg <= pwdata[30:0];
                CFG_RADIUS_Y: radius_y_reg <= pwdata[30:0];
                CFG_RADIUS_Z: radius_z_reg <= pwdata[30:0];
                CFG_RINGS:    rings_reg    <= wr_rings;
                CFG_SIDES:    sides_reg    <= wr_sides;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (wr_idx)
            CFG_CENTER_X: prdata = center_x_reg;
            CFG_CENTER_Y: prdata = center_y_reg;
            CFG_CENTER_Z: prdata = center_z_reg;
            CFG_RADIUS_X: prdata = 32'(radius_x_reg);
            CFG_RADIUS_Y: prdata = 32'(radius_y_reg);
            CFG_RADIUS_Z: prdata = 32'(radius_z_reg);
            CFG_RINGS:    prdata = 32'(rings_reg);
            CFG_SIDES:    prdata = 32'(sides_reg);
            default:      prdata = '0;
        endcase
    end

    // ------------------------------------------------------------- control
    assign adv     = !vld_reg[TOTAL-1] || m_ready;
    assign s_ready = adv;
    assign m_valid = vld_reg[TOTAL-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[TOTAL-2:0], s_valid};
        end
    end

    // ------------------------------------------------------ octant split
    assign np  = EW'(rings_reg) << 1;
    assign nt  = EW'(sides_reg);
    assign ep2 = EW'(ring2_reg) << 3;
    assign et2 = EW'(side2_reg) << 3;

    always_comb begin
        logic [EW-1:0] e1p;
        logic [EW-1:0] e1t;
        e1p = EW'(ring1_reg) << 3;
        e1t = EW'(side1_reg) << 3;
        op_next = '0;
        ot_next = '0;
        for (int k = 1; k <= 8; k++) begin
            op_next = op_next + 4'(e1p >= EW'(k) * np);
            ot_next = ot_next + 4'(e1t >= EW'(k) * nt);
        end
        rp_w = ep2 - EW'(op_reg) * np;
        rt_w = et2 - EW'(ot_reg) * nt;
        if (op_reg[0]) begin
            rp_w = np - rp_w;
        end
        if (ot_reg[0]) begin
            rt_w = nt - rt_w;
        end
        num[0] = NW'(rp_reg) * NW'(PI_Q28);
        num[1] = NW'(rt_reg) * NW'(PI_Q28);
        num[2] = nth_reg;
        num[3] = nph_reg;
        dv_div[0] = DW'(np);
        dv_div[1] = DW'(nt);
        dv_div[2] = DW'(nt);
        dv_div[3] = DW'(rings_reg);
    end

    always_comb begin
        for (int k = 1; k <= QW; k++) begin
            for (int l = 0; l < 4; l++) begin
                dv_tr[l][k] = {dv_rem_reg[l][k-1], dv_lo_reg[l][k-1][QW-1]};
                dv_ge[l][k] = dv_tr[l][k] >= {1'b0, dv_div[l]};
            end
        end
        for (int l = 0; l < 4; l++) begin
            dv_tr[l][0] = '0;
            dv_ge[l][0] = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ring1_reg <= (s_ring_index > rings_reg) ? rings_reg : s_ring_index;
            side1_reg <= (s_side_index > sides_reg) ? sides_reg : s_side_index;
            ring2_reg <= ring1_reg;
            side2_reg <= side1_reg;
            op_reg    <= op_next;
            ot_reg    <= ot_next;
            rp_reg    <= DW'(rp_w);
            rt_reg    <= DW'(rt_w);
            ctlp_reg  <= '{odd: op_reg[0], quad: op_reg[2:1]};
            ctlt_reg  <= '{odd: ot_reg[0], quad: ot_reg[2:1]};
            nth_reg   <= NW'(side2_reg) * NW'(TWO_PI_Q28);
            nph_reg   <= NW'(ring2_reg) * NW'(PI_Q28);
            for (int l = 0; l < 4; l++) begin
                dv_rem_reg[l][0] <= num[l][NW-1:QW];
                dv_lo_reg[l][0]  <= num[l][QW-1:0];
            end
            dv_ctl_reg[0][0] <= ctlp_reg;
            dv_ctl_reg[1][0] <= ctlt_reg;
            for (int k = 1; k <= QW; k++) begin
                for (int l = 0; l < 4; l++) begin
                    dv_rem_reg[l][k] <= dv_ge[l][k] ?
                        DW'(dv_tr[l][k] - {1'b0, dv_div[l]}) : dv_tr[l][k][DW-1:0];
                    dv_lo_reg[l][k] <= {dv_lo_reg[l][k-1][QW-2:0], dv_ge[l][k]};
                end
                dv_ctl_reg[0][k] <= dv_ctl_reg[0][k-1];
                dv_ctl_reg[1][k] <= dv_ctl_reg[1][k-1];
            end
        end
    end

    // ---------------------------------------------------------- sin / cos
    uvs_sincos u_sc_polar (
        .aclk  (aclk),
        .en    (adv),
        .x     (dv_lo_reg[0][QW][29:0]),
        .ctl   (dv_ctl_reg[0][QW]),
        .sin_q (sp),
        .cos_q (cp)
    );

    uvs_sincos u_sc_azim (
        .aclk  (aclk),
        .en    (adv),
        .x     (dv_lo_reg[1][QW][29:0]),
        .ctl   (dv_ctl_reg[1][QW]),
        .sin_q (st),
        .cos_q (ct)
    );

    // ------------------------------------------------------------ texture
    assign ur     = 64'(pu_reg) + 64'(1 << 28);
    assign vr     = 64'(pv_reg) + 64'(1 << 27);
    assign u_next = (|ur[63:60]) ? 31'h7FFF_FFFF : 31'(ur[59:29]);
    assign v_next = (|vr[63:59]) ? 31'h7FFF_FFFF : 31'(vr[58:28]);

    always_ff @(posedge aclk) begin
        if (adv) begin
            pu_reg   <= 63'(dv_lo_reg[2][QW]) *
                        63'(32'(radius_x_reg) + 32'(radius_z_reg));
            pv_reg   <= 62'(dv_lo_reg[3][QW]) * 62'(radius_y_reg);
            u_reg[0] <= u_next;
            v_reg[0] <= v_next;
            for (int s = 1; s <= SC_LAT + 1; s++) begin
                u_reg[s] <= u_reg[s-1];
                v_reg[s] <= v_reg[s-1];
            end
        end
    end

    // ------------------------------------------------------- normal, pos
    always_ff @(posedge aclk) begin
        if (adv) begin
            nx_reg    <= smul30(sp, ct);
            ny_reg    <= cp;
            nz_reg    <= smul30(sp, st);
            pmx_reg   <= scale(nx_reg, radius_x_reg);
            pmy_reg   <= scale(ny_reg, radius_y_reg);
            pmz_reg   <= scale(nz_reg, radius_z_reg);
            ngx_reg   <= nx_reg[31];
            ngy_reg   <= ny_reg[31];
            ngz_reg   <= nz_reg[31];
            qx_reg    <= to_q14(nx_reg);
            qy_reg    <= to_q14(ny_reg);
            qz_reg    <= to_q14(nz_reg);
            posx_reg  <= place(center_x_reg, pmx_reg, ngx_reg);
            posy_reg  <= place(center_y_reg, pmy_reg, ngy_reg);
            posz_reg  <= place(center_z_reg, pmz_reg, ngz_reg);
            normx_reg <= qx_reg;
            normy_reg <= qy_reg;
            normz_reg <= qz_reg;
        end
    end

    assign m_pos_x  = posx_reg;
    assign m_pos_y  = posy_reg;
    assign m_pos_z  = posz_reg;
    assign m_norm_x = normx_reg;
    assign m_norm_y = normy_reg;
    assign m_norm_z = normz_reg;
    assign m_tex_u  = u_reg[SC_LAT+1];
    assign m_tex_v  = v_reg[SC_LAT+1];

endmodule

// ===== verif/vertex_checker.sv =====
// ----------------------------------------------------------------------------
// vertex_checker
// Watches the register port and both word channels of the UV-sphere vertex
// generator, predicts every vertex from its own copy of the registers and
// compares the results field by field, in order.
// ----------------------------------------------------------------------------
module vertex_checker
    import uvs_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [31:0]         pwdata,
    input  logic                pready,
    input  logic                s_valid,
    input  logic                s_ready,
    input  logic [5:0]          s_ring_index,
    input  logic [6:0]          s_side_index,
    input  logic                m_valid,
    input  logic                m_ready,
    input  logic signed [31:0]  m_pos_x,
    input  logic signed [31:0]  m_pos_y,
    input  logic signed [31:0]  m_pos_z,
    input  logic signed [15:0]  m_norm_x,
    input  logic signed [15:0]  m_norm_y,
    input  logic signed [15:0]  m_norm_z,
    input  logic [30:0]         m_tex_u,
    input  logic [30:0]         m_tex_v,
    output int                  fails,
    output int                  pending
);

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [15:0] norm_x;
        logic signed [15:0] norm_y;
        logic signed [15:0] norm_z;
        logic [30:0]        tex_u;
        logic [30:0]        tex_v;
    } vertex_t;

    localparam logic [63:0] ONE = 64'd1 << 30;
    localparam logic [63:0] PI4 = 64'(PI_Q28);

    longint      ctr_x, ctr_y, ctr_z;
    logic [30:0] rad_x, rad_y, rad_z;
    logic [31:0] rings, sides;
    vertex_t     vertex_q[$];

    function automatic logic [63:0] m30(logic [63:0] a, logic [63:0] b);
        return (a * b) >> 30;
    endfunction

    function automatic void series(input logic [63:0] x,
                                   output logic [63:0] s, output logic [63:0] c);
        logic [63:0] x2, t;
        x2 = m30(x, x);
        t = ONE - x2 / 72;
        t = ONE - m30(x2, t) / 42;
        t = ONE - m30(x2, t) / 20;
        t = ONE - m30(x2, t) / 6;
        s = m30(x, t);
        t = ONE - x2 / 56;
        t = ONE - m30(x2, t) / 30;
        t = ONE - m30(x2, t) / 12;
        c = ONE - m30(x2, t) / 2;
    endfunction

    // sin and cos of a full turn times a/n, signed Q30
    function automatic void turn(input logic [31:0] a, input logic [31:0] n,
                                 output longint so, output longint co);
        logic [31:0] e, o, r;
        logic [63:0] ps, pc, qs, qc;
        e = 8 * a;
        o = e / n;
        r = e - o * n;
        if (o[0]) r = n - r;
        series((64'(r) * PI4) / 64'(n), ps, pc);
        if (o[0]) begin
            qs = pc; qc = ps;
        end else begin
            qs = ps; qc = pc;
        end
        case (o[2:1])
            2'd0: begin so = longint'(qs);  co = longint'(qc);  end
            2'd1: begin so = longint'(qc);  co = -longint'(qs); end
            2'd2: begin so = -longint'(qs); co = -longint'(qc); end
            default: begin so = -longint'(qc); co = longint'(qs); end
        endcase
    endfunction

    function automatic logic [63:0] absv(longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic longint rmul30(longint a, longint b);
        logic [63:0] p;
        p = (absv(a) * absv(b) + (64'd1 << 29)) >> 30;
        return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
    endfunction

    function automatic logic [15:0] norm_q14(longint v);
        logic [63:0] r;
        r = (absv(v) + 64'd32768) >> 16;
        return v < 0 ? 16'(-longint'(r)) : 16'(r);
    endfunction

    function automatic logic [31:0] place(longint c, longint n, logic [30:0] rad);
        logic [63:0] p;
        longint s;
        p = (absv(n) * 64'(rad) + (64'd1 << 29)) >> 30;
        s = c + (n < 0 ? -longint'(p) : longint'(p));
        if (s > 64'sd2147483647) s = 64'sd2147483647;
        if (s < -64'sd2147483648) s = -64'sd2147483648;
        return 32'(s);
    endfunction

    function automatic vertex_t vertex_of(logic [5:0] ri, logic [6:0] si);
        vertex_t v;
        logic [31:0] ring, side;
        longint sp, cp, st, ct, nx, ny, nz;
        logic [63:0] theta, phi, u, w;
        ring = 32'(ri) > rings ? rings : 32'(ri);
        side = 32'(si) > sides ? sides : 32'(si);
        turn(ring, 2 * rings, sp, cp);
        turn(side, sides, st, ct);
        nx = rmul30(sp, ct);
        ny = cp;
        nz = rmul30(sp, st);
        v.pos_x = place(ctr_x, nx, rad_x);
        v.pos_y = place(ctr_y, ny, rad_y);
        v.pos_z = place(ctr_z, nz, rad_z);
        v.norm_x = norm_q14(nx);
        v.norm_y = norm_q14(ny);
        v.norm_z = norm_q14(nz);
        theta = (64'(side) * 2 * PI4) / 64'(sides);
        phi = (64'(ring) * PI4) / 64'(rings);
        u = (theta * (64'(rad_x) + 64'(rad_z)) + (64'd1 << 28)) >> 29;
        w = (phi * 64'(rad_y) + (64'd1 << 27)) >> 28;
        v.tex_u = u > 64'h7FFFFFFF ? 31'h7FFFFFFF : 31'(u);
        v.tex_v = w > 64'h7FFFFFFF ? 31'h7FFFFFFF : 31'(w);
        return v;
    endfunction

    function automatic logic [31:0] clamp_count(logic [31:0] v, logic [31:0] lo,
                                                logic [31:0] hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    vertex_t got, want;

    always @(posedge aclk) begin
        if (!aresetn) begin
            ctr_x <= 0; ctr_y <= 0; ctr_z <= 0;
            rad_x <= 31'd65536; rad_y <= 31'd65536; rad_z <= 31'd65536;
            rings <= 16; sides <= 32;
            vertex_q.delete();
            fails <= 0;
            pending <= 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (cfg_reg_t'(paddr[4:2]))
                    CFG_CENTER_X: ctr_x <= longint'(signed'(pwdata));
                    CFG_CENTER_Y: ctr_y <= longint'(signed'(pwdata));
                    CFG_CENTER_Z: ctr_z <= longint'(signed'(pwdata));
                    CFG_RADIUS_X: rad_x <= pwdata[30:0];
                    CFG_RADIUS_Y: rad_y <= pwdata[30:0];
                    CFG_RADIUS_Z: rad_z <= pwdata[30:0];
                    CFG_RINGS:    rings <= clamp_count(32'(pwdata[5:0]), 2, 32);
                    CFG_SIDES:    sides <= clamp_count(32'(pwdata[6:0]), 3, 64);
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                vertex_q.push_back(vertex_of(s_ring_index, s_side_index));
            if (m_valid && m_ready) begin
                got = '{m_pos_x, m_pos_y, m_pos_z, m_norm_x, m_norm_y, m_norm_z,
                        m_tex_u, m_tex_v};
                if (vertex_q.size() == 0) begin
                    if (fails < 10)
                        $display("unexpected vertex word %p", got);
                    fails <= fails + 1;
                end else begin
                    want = vertex_q.pop_front();
                    if (got != want) begin
                        if (fails < 10) begin
                            $display("vertex mismatch");
                            $display("  pos  exp %0d %0d %0d got %0d %0d %0d",
                                     want.pos_x, want.pos_y, want.pos_z,
                                     got.pos_x, got.pos_y, got.pos_z);
                            $display("  norm exp %0d %0d %0d got %0d %0d %0d",
                                     want.norm_x, want.norm_y, want.norm_z,
                                     got.norm_x, got.norm_y, got.norm_z);
                            $display("  uv   exp %0d %0d got %0d %0d",
                                     want.tex_u, want.tex_v, got.tex_u, got.tex_v);
                        end
                        fails <= fails + 1;
                    end
                end
            end
            pending <= vertex_q.size();
        end
    end

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives grid points and register settings into the UV-sphere vertex
// generator under random idling on both channels, except in the last phase;
// the checker predicts and compares every vertex word.
// ----------------------------------------------------------------------------
module testbench;
    import uvs_pkg::*;

    localparam int LIMIT = 1000000;

    logic               aclk;
    logic               aresetn;
    logic               psel, penable, pwrite;
    logic [APB_AW-1:0]  paddr;
    logic [31:0]        pwdata, prdata;
    logic               pready;
    logic               s_valid, s_ready;
    logic [5:0]         s_ring_index;
    logic [6:0]         s_side_index;
    logic               m_valid, m_ready;
    logic signed [31:0] m_pos_x, m_pos_y, m_pos_z;
    logic signed [15:0] m_norm_x, m_norm_y, m_norm_z;
    logic [30:0]        m_tex_u, m_tex_v;
    int                 fails, pending, cycles, stall_left;
    bit                 idling;

    uv_sphere_vertex_generator dut (.*);
    vertex_checker chk (.*);

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // result side back-pressure
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            m_ready <= 1'b0;
        end else if (idling && $urandom_range(7, 0) == 0) begin
            stall_left = $urandom_range(7, 1) - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic reg_write(cfg_reg_t r, logic [31:0] v);
        @(posedge aclk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= APB_AW'(r) << 2; pwdata <= v;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic send(logic [5:0] ring, logic [6:0] side);
        if (idling && $urandom_range(5, 0) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(7, 1)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_ring_index <= ring;
        s_side_index <= side;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    function automatic logic [31:0] pick(logic [31:0] lo, logic [31:0] hi);
        case ($urandom_range(3, 0))
            0: return lo;
            1: return hi;
            default: return $urandom();
        endcase
    endfunction

    initial begin
        logic [31:0] nr, ns;
        aresetn = 0; psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        s_valid = 0; s_ring_index = '0; s_side_index = '0; m_ready = 0;
        cycles = 0; stall_left = 0; idling = 1;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // poles, seams, octant points and indices beyond the counts
        send(0, 0);   send(16, 32); send(63, 127); send(8, 8);
        send(4, 4);   send(12, 24); send(1, 1);    send(15, 31);
        send(8, 16);  send(2, 12);  send(17, 33);  send(6, 20);
        drain();

        for (int ph = 0; ph < 9; ph++) begin
            if (ph == 8) idling = 0;
            if (ph == 0) begin
                reg_write(CFG_RINGS, 0);  reg_write(CFG_SIDES, 0);
                reg_write(CFG_RADIUS_X, 32'h7FFFFFFF);
                reg_write(CFG_RADIUS_Y, 32'h7FFFFFFF);
                reg_write(CFG_RADIUS_Z, 32'h7FFFFFFF);
                reg_write(CFG_CENTER_X, 32'h7FFFFFFF);
                reg_write(CFG_CENTER_Y, 32'h80000000);
                reg_write(CFG_CENTER_Z, 32'h7FFFFFFF);
            end else if (ph == 1) begin
                reg_write(CFG_RINGS, 63); reg_write(CFG_SIDES, 127);
                reg_write(CFG_RADIUS_X, 0); reg_write(CFG_RADIUS_Y, 0);
                reg_write(CFG_RADIUS_Z, 0);
                reg_write(CFG_CENTER_X, 32'h80000000);
                reg_write(CFG_CENTER_Y, 32'h7FFFFFFF);
                reg_write(CFG_CENTER_Z, 32'h80000000);
            end else begin
                reg_write(CFG_RINGS, $urandom());
                reg_write(CFG_SIDES, $urandom());
                reg_write(CFG_RADIUS_X, pick(0, 32'h7FFFFFFF));
                reg_write(CFG_RADIUS_Y, pick(0, 32'h7FFFFFFF));
                reg_write(CFG_RADIUS_Z, pick(0, 32'h7FFFFFFF));
                reg_write(CFG_CENTER_X, pick(32'h80000000, 32'h7FFFFFFF));
                reg_write(CFG_CENTER_Y, pick(32'h80000000, 32'h7FFFFFFF));
                reg_write(CFG_CENTER_Z, pick(32'h80000000, 32'h7FFFFFFF));
            end
            for (int i = 0; i < 220; i++) begin
                if ($urandom_range(9, 0) == 0)
                    send(6'($urandom()), 7'($urandom()));
                else
                    send(6'($urandom_range(32, 0)), 7'($urandom_range(64, 0)));
            end
            drain();
        end

        while (pending != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
        if (fails == 0 && pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
